[rtl/wmf2d_pkg.sv]
// ----------------------------------------------------------------------------
// wmf2d_pkg
// Shared widths, register indexes and helpers of the weighted mean filter.
// ----------------------------------------------------------------------------
package wmf2d_pkg;

   localparam int PIX_W     = 8;    // gray pixel
   localparam int ROW_W     = 9;    // row counters wrap modulo 512
   localparam int FRAME_W   = 10;   // frame height may reach 512
   localparam int RING_W    = 3;    // eight rows in the line store ring
   localparam int RING_ROWS = 8;
   localparam int KSIZE_W   = 3;    // kernel size and tap counters
   localparam int FLUSH_W   = 11;
   localparam logic [FLUSH_W-1:0] FLUSH_SAT = 11'd2047;
   localparam int IW_W      = 9;    // image width register
   localparam int CSR_W     = 40;
   localparam int CSR_IDX_W = 3;
   localparam int COEF_ROWS = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ROW_FOUR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROWS   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_COLS   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd7;

   // One coefficient of a packed kernel row; columns beyond the fifth are zero.
   function automatic logic [PIX_W-1:0] coef_pick(input logic [CSR_W-1:0] row,
                                                  input logic [KSIZE_W-1:0] col);
      logic [PIX_W-1:0] k;
      case (col)
         3'd0:    k = row[7:0];
         3'd1:    k = row[15:8];
         3'd2:    k = row[23:16];
         3'd3:    k = row[31:24];
         3'd4:    k = row[39:32];
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

[rtl/weighted_mean_filter_2d.sv]
// ----------------------------------------------------------------------------
// weighted_mean_filter_2d
// Streaming 2-D weighted mean filter for 8-bit gray pixels in raster order.
// ----------------------------------------------------------------------------
// Usage: pixels enter on the req_ channel (valid/ready), one request per pixel
// in raster order. After the last pixel of a frame the source sends flush
// requests; they push the delayed window out and mark the bottom border. The
// rsp_ channel returns one pixel per request once the pipeline lead of
// (kernel_rows/2)*image_width + kernel_cols/2 requests has been built up. The
// final pixel of a frame carries rsp_last_of_frame, after which all position
// counters are back at zero and the next pixel starts a new frame.
// Sequence: a request that produces no response leaves the control idle. A
// border pixel passes the center read and then the done state. An interior
// pixel also visits every tap: each is one read of the single-port line store
// followed by a multiply-accumulate, and the quotient is then formed one bit
// per cycle. When the coefficients sum to zero the quotient steps are skipped.
// The line store takes the incoming pixel in the accept cycle; all window
// reads come later, so reads and writes never collide on one port.
// Reset restores state, counters, configuration and rsp_valid; the job and
// output data registers and the line store are not cleared. When the receiver
// stalls, a finished response stays in the output register; the next request
// is still accepted and processed, and only its response waits for the register.
// Configuration is written through csr_wr_en/csr_index/csr_wr_data while idle.
// ----------------------------------------------------------------------------
module weighted_mean_filter_2d
   import wmf2d_pkg::*;
#(
   parameter int KERNEL_MAX = 5,
   parameter int MAX_WIDTH  = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIX_W-1:0]     req_pixel_in,
   input  logic                 req_flush,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PIX_W-1:0]     rsp_pixel_out,
   output logic                 rsp_last_of_frame,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wr_data
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int DEPTH = RING_ROWS * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int HK    = KERNEL_MAX / 2;
   localparam int LW    = $clog2(HK * MAX_WIDTH + HK + 2);
   localparam int ACC_W = $clog2(KERNEL_MAX * KERNEL_MAX * 255 * 255 + 1);
   localparam int SUM_W = $clog2(KERNEL_MAX * KERNEL_MAX * 255 + 1);
   localparam int DV_W  = ACC_W + PIX_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CTR  = 3'd1;
   localparam logic [2:0] ST_CTRW = 3'd2;
   localparam logic [2:0] ST_TRD  = 3'd3;
   localparam logic [2:0] ST_TACC = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   // Configuration registers.
   logic [CSR_W-1:0]   coef_ff [COEF_ROWS];
   logic [KSIZE_W-1:0] krows_ff, kcols_ff;
   logic [IW_W-1:0]    iw_ff;

   // Frame position state.
   logic [CW-1:0]      in_col_ff, out_col_ff;
   logic [ROW_W-1:0]   in_row_ff, out_row_ff;
   logic [FLUSH_W-1:0] fcount_ff;
   logic [FRAME_W-1:0] frame_rows_ff;
   logic [LW-1:0]      lead_ff;

   // Job state of the pixel being filtered.
   logic [2:0]         state_ff;
   logic [ROW_W-1:0]   job_i_ff;
   logic [CW-1:0]      job_j_ff;
   logic               border_ff, last_ff;
   logic [KSIZE_W-1:0] ta_ff, tb_ff, dcnt_ff;
   logic [ACC_W-1:0]   acc_ff, rem_ff;
   logic [SUM_W-1:0]   wsum_ff;
   logic [PIX_W-1:0]   quo_ff, result_ff;

   // Output register.
   logic               rsp_valid_ff, rsp_last_ff;
   logic [PIX_W-1:0]   rsp_pixel_ff;

   // Line store.
   logic [PIX_W-1:0]   mem [DEPTH];
   logic [PIX_W-1:0]   mem_rd_ff;
   logic [AW-1:0]      mem_ra, mem_wa;
   logic               mem_we;

   // Derived sizes.
   logic [KSIZE_W-1:0] kr, kc, hr, hc;
   logic [WW-1:0]      w;
   logic [LW-1:0]      lag;

   // Accept-time arithmetic.
   logic               accept, first_flush, empty_flush, flushing, emit;
   logic [WW:0]        c0, c1, oc0, oc1;
   logic [ROW_W-1:0]   r0, r1, or0, or1, last_row;
   logic [FRAME_W-1:0] fr_in;
   logic [FLUSH_W-1:0] fcount_in;
   logic [PIX_W-1:0]   wr_pix;
   logic               border_in, last_in;

   // Tap arithmetic.
   logic [RING_W-1:0]  tap_row;
   logic [WW:0]        tap_col;
   logic [PIX_W-1:0]   k;
   logic [ACC_W-1:0]   acc_in;
   logic [SUM_W-1:0]   wsum_in;
   logic [DV_W-1:0]    dv;
   logic               ge;
   logic [PIX_W-1:0]   quo_in;
   logic               out_free;

   function automatic logic [AW-1:0] addr_of(input logic [RING_W-1:0] row,
                                             input logic [CW-1:0] col);
      return AW'(int'(row) * MAX_WIDTH + int'(col));
   endfunction

   // Sizes out of range act as the nearest legal value.
   always_comb begin
      if (krows_ff == '0) begin
         kr = KSIZE_W'(1);
      end else if (32'(krows_ff) > KERNEL_MAX) begin
         kr = KSIZE_W'(KERNEL_MAX);
      end else begin
         kr = krows_ff;
      end
      if (kcols_ff == '0) begin
         kc = KSIZE_W'(1);
      end else if (32'(kcols_ff) > KERNEL_MAX) begin
         kc = KSIZE_W'(KERNEL_MAX);
      end else begin
         kc = kcols_ff;
      end
      if (iw_ff == '0) begin
         w = WW'(1);
      end else if (32'(iw_ff) > MAX_WIDTH) begin
         w = WW'(MAX_WIDTH);
      end else begin
         w = WW'(iw_ff);
      end
      hr  = kr >> 1;
      hc  = kc >> 1;
      lag = LW'(32'(hr) * 32'(w) + 32'(hc));
   end

   assign accept = req_valid && req_ready;

   // Position bookkeeping for one request. Counters that a width change left
   // past the row end wrap first.
   always_comb begin
      c0 = (WW+1)'(in_col_ff);
      r0 = in_row_ff;
      if (c0 >= (WW+1)'(w)) begin
         c0 = '0;
         r0 = r0 + 1'b1;
      end
      oc0 = (WW+1)'(out_col_ff);
      or0 = out_row_ff;
      if (oc0 >= (WW+1)'(w)) begin
         oc0 = '0;
         or0 = or0 + 1'b1;
      end
      first_flush = (fcount_ff == '0) && req_flush;
      empty_flush = first_flush && (r0 == '0) && (c0 == '0);
      fr_in       = first_flush ? FRAME_W'(r0) + FRAME_W'(c0 != '0) : frame_rows_ff;
      flushing    = (fcount_ff != '0) || req_flush;
      fcount_in   = (flushing && fcount_ff != FLUSH_SAT) ? fcount_ff + 1'b1 : fcount_ff;
      wr_pix      = flushing ? '0 : req_pixel_in;
      c1 = c0 + 1'b1;
      r1 = r0;
      if (c1 >= (WW+1)'(w)) begin
         c1 = '0;
         r1 = r0 + 1'b1;
      end
      emit = lead_ff >= lag;
      oc1  = oc0 + 1'b1;
      or1  = or0;
      if (oc1 >= (WW+1)'(w)) begin
         oc1 = '0;
         or1 = or0 + 1'b1;
      end
      border_in = (or0 < ROW_W'(hr)) || (oc0 < (WW+1)'(hc)) ||
                  (oc0 + (WW+1)'(hc) >= (WW+1)'(w)) ||
                  ((fcount_in != '0) && (FRAME_W'(or0) + FRAME_W'(hr) >= fr_in));
      last_row  = fr_in[ROW_W-1:0] - 1'b1;
      last_in   = (fcount_in != '0) && (or0 == last_row) &&
                  (oc0 == (WW+1)'(w) - 1'b1);
   end

   // Tap address and coefficient; kernel columns are mirrored.
   always_comb begin
      tap_row = job_i_ff[RING_W-1:0] - RING_W'(hr) + RING_W'(ta_ff);
      tap_col = (WW+1)'(job_j_ff) + (WW+1)'(hc) - (WW+1)'(tb_ff);
      case (ta_ff)
         3'd0:    k = coef_pick(coef_ff[0], tb_ff);
         3'd1:    k = coef_pick(coef_ff[1], tb_ff);
         3'd2:    k = coef_pick(coef_ff[2], tb_ff);
         3'd3:    k = coef_pick(coef_ff[3], tb_ff);
         3'd4:    k = coef_pick(coef_ff[4], tb_ff);
         default: k = '0;
      endcase
      acc_in  = acc_ff + ACC_W'(mem_rd_ff) * ACC_W'(k);
      wsum_in = wsum_ff + SUM_W'(k);
      dv      = DV_W'(wsum_ff) << dcnt_ff;
      ge      = DV_W'(rem_ff) >= dv;
      quo_in  = quo_ff | (ge ? (PIX_W'(1) << dcnt_ff) : '0);
   end

   always_comb begin
      mem_we = accept && !empty_flush;
      mem_wa = addr_of(r0[RING_W-1:0], CW'(c0));
      case (state_ff)
         ST_CTR:  mem_ra = addr_of(job_i_ff[RING_W-1:0], job_j_ff);
         default: mem_ra = addr_of(tap_row, CW'(tap_col));
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= wr_pix;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < COEF_ROWS; n++) begin
            coef_ff[n] <= '0;
         end
         krows_ff <= KSIZE_W'(3);
         kcols_ff <= KSIZE_W'(3);
         iw_ff    <= IW_W'(256);
      end else if (csr_wr_en) begin
         if (csr_index <= CSR_COEF_ROW_FOUR) begin
            coef_ff[csr_index] <= csr_wr_data;
         end else if (csr_index == CSR_KERNEL_ROWS) begin
            krows_ff <= csr_wr_data[KSIZE_W-1:0];
         end else if (csr_index == CSR_KERNEL_COLS) begin
            kcols_ff <= csr_wr_data[KSIZE_W-1:0];
         end else if (csr_index == CSR_IMAGE_WIDTH) begin
            iw_ff <= csr_wr_data[IW_W-1:0];
         end
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Position counters, sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         fcount_ff     <= '0;
         frame_rows_ff <= '0;
         lead_ff       <= '0;
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // In the done state the output register is reloaded instead.
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (empty_flush) begin
                     in_col_ff  <= CW'(c0);
                     in_row_ff  <= r0;
                     out_col_ff <= CW'(oc0);
                     out_row_ff <= or0;
                  end else if (emit && last_in) begin
                     // End of frame: everything starts over with the next pixel.
                     in_col_ff     <= '0;
                     in_row_ff     <= '0;
                     out_col_ff    <= '0;
                     out_row_ff    <= '0;
                     fcount_ff     <= '0;
                     frame_rows_ff <= '0;
                     lead_ff       <= '0;
                  end else begin
                     in_col_ff     <= CW'(c1);
                     in_row_ff     <= r1;
                     fcount_ff     <= fcount_in;
                     frame_rows_ff <= fr_in;
                     lead_ff       <= emit ? lead_ff : lead_ff + 1'b1;
                     out_col_ff    <= emit ? CW'(oc1) : CW'(oc0);
                     out_row_ff    <= emit ? or1 : or0;
                  end
                  if (!empty_flush && emit) begin
                     state_ff <= ST_CTR;
                  end
               end
            end
            ST_CTR: begin
               state_ff <= ST_CTRW;
            end
            ST_CTRW: begin
               state_ff <= border_ff ? ST_DONE : ST_TRD;
            end
            ST_TRD: begin
               state_ff <= ST_TACC;
            end
            ST_TACC: begin
               if (tb_ff == kc - 1'b1 && ta_ff == kr - 1'b1) begin
                  state_ff <= (wsum_in == '0) ? ST_DONE : ST_DIV;
               end else begin
                  state_ff <= ST_TRD;
               end
            end
            ST_DIV: begin
               if (dcnt_ff == '0) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Job datapath; needs no reset.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            job_i_ff  <= or0;
            job_j_ff  <= CW'(oc0);
            border_ff <= border_in;
            last_ff   <= last_in;
         end
         ST_CTRW: begin
            // The center pixel is the answer for borders and for a zero sum.
            result_ff <= mem_rd_ff;
            ta_ff     <= '0;
            tb_ff     <= '0;
            acc_ff    <= '0;
            wsum_ff   <= '0;
         end
         ST_TACC: begin
            acc_ff  <= acc_in;
            wsum_ff <= wsum_in;
            if (tb_ff == kc - 1'b1) begin
               tb_ff <= '0;
               ta_ff <= ta_ff + 1'b1;
            end else begin
               tb_ff <= tb_ff + 1'b1;
            end
            rem_ff  <= acc_in;
            quo_ff  <= '0;
            dcnt_ff <= KSIZE_W'(PIX_W - 1);
         end
         ST_DIV: begin
            // Restoring division; the mean never exceeds one pixel.
            if (ge) begin
               rem_ff <= ACC_W'(DV_W'(rem_ff) - dv);
            end
            quo_ff  <= quo_in;
            dcnt_ff <= dcnt_ff - 1'b1;
            if (dcnt_ff == '0) begin
               result_ff <= quo_in;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_pixel_ff <= result_ff;
               rsp_last_ff  <= last_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_out     = rsp_pixel_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   // A weighted mean fits in one pixel, so the top quotient step has room.
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && dcnt_ff == KSIZE_W'(PIX_W - 1)) |->
      (DV_W'(rem_ff) < (DV_W'(wsum_ff) << PIX_W)))
      else $error("weighted sum exceeds one pixel times the coefficient sum");

   // Tap counters stay inside the kernel in use.
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRD || state_ff == ST_TACC) |-> (ta_ff < kr && tb_ff < kc))
      else $error("tap counter outside kernel");

   // The frame is restarted by the time its last pixel is answered.
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && last_ff) |->
      (in_col_ff == '0 && in_row_ff == '0 && fcount_ff == '0 && lead_ff == '0))
      else $error("frame state not cleared after last pixel");

endmodule
